[rtl/core/u8f_pkg.sv]
// shared types, codes and constants of the utf-8 decode and character filter unit
package u8f_pkg;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_ACCEPT = 3'd1,
        KIND_FORBID = 3'd2,
        KIND_FONT   = 3'd3,
        KIND_BAD    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        REF_NONE   = 2'd0,
        REF_FORBID = 2'd1,
        REF_FONT   = 2'd2,
        REF_BAD    = 2'd3
    } refusal_t;

    localparam logic [1:0] MODE_FREE = 2'd0;
    localparam logic [1:0] MODE_NAME = 2'd1;
    localparam logic [1:0] MODE_ROOM = 2'd2;

    localparam logic CFG_FILTER_MODE = 1'b0;
    localparam logic CFG_MASKED_MODE = 1'b1;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] CP_MAX        = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO       = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI       = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_TWO       = 21'h000080;
    localparam logic [CP_W-1:0] MIN_THREE     = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR      = 21'h010000;
    localparam logic [CP_W-1:0] CTRL_LIMIT    = 21'h000020;
    localparam logic [CP_W-1:0] DEL_CHAR      = 21'h00007F;
    localparam logic [CP_W-1:0] PRINT_LAST    = 21'h00007E;

    typedef struct packed {
        kind_t           kind;
        logic [CP_W-1:0] kept;
    } judge_t;

    typedef struct packed {
        kind_t           kind;
        logic [CP_W-1:0] code_point;
        refusal_t        first_refusal;
    } result_t;

    // room code alphabet: A-Z without I and O, then 2-9
    function automatic logic room_symbol(input logic [6:0] c);
        logic letter;
        logic digit;
        letter = (c >= 7'h41) && (c <= 7'h5A) && (c != 7'h49) && (c != 7'h4F);
        digit  = (c >= 7'h32) && (c <= 7'h39);
        return letter || digit;
    endfunction

endpackage

[rtl/core/u8f_judge.sv]
// character filter: judges one complete code point against the filter mode
module u8f_judge (
    input  logic [u8f_pkg::CP_W-1:0] value,
    input  logic [1:0]               filter_mode,
    input  logic                     masked_mode,
    output u8f_pkg::judge_t          verdict
);

    logic       is_ctrl;
    logic       is_wide;
    logic [6:0] low7;
    logic [6:0] upper;
    logic       is_lower;
    logic       name_ok;

    always_comb
    begin
        low7     = value[6:0];
        is_ctrl  = (value < u8f_pkg::CTRL_LIMIT) || (value == u8f_pkg::DEL_CHAR);
        is_wide  = value > u8f_pkg::PRINT_LAST;
        is_lower = (low7 >= 7'h61) && (low7 <= 7'h7A);
        upper    = is_lower ? (low7 - 7'h20) : low7;
        name_ok  = ((low7 >= 7'h41) && (low7 <= 7'h5A)) || is_lower
                 || ((low7 >= 7'h30) && (low7 <= 7'h39))
                 || (low7 == 7'h2D) || (low7 == 7'h5F);

        verdict.kind = u8f_pkg::KIND_ACCEPT;
        verdict.kept = value;
        priority if (is_ctrl)
        begin
            verdict.kind = u8f_pkg::KIND_FORBID;
            verdict.kept = '0;
        end
        else if (is_wide)
        begin
            if (!(masked_mode && (filter_mode == u8f_pkg::MODE_FREE)))
            begin
                verdict.kind = u8f_pkg::KIND_FONT;
                verdict.kept = '0;
            end
        end
        else if (filter_mode == u8f_pkg::MODE_NAME)
        begin
            if (!name_ok)
            begin
                verdict.kind = u8f_pkg::KIND_FORBID;
                verdict.kept = '0;
            end
        end
        else if (filter_mode == u8f_pkg::MODE_ROOM)
        begin
            if (u8f_pkg::room_symbol(upper))
            begin
                verdict.kept = {14'd0, upper};
            end
            else
            begin
                verdict.kind = u8f_pkg::KIND_FORBID;
                verdict.kept = '0;
            end
        end
        else
        begin
            verdict.kept = value;
        end
    end

endmodule

[rtl/core/u8f_decode.sv]
// utf-8 sequence state, malformed checks and first-refusal tracking for one byte
module u8f_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        byte_value,
    input  logic              end_of_string,
    input  logic [1:0]        filter_mode,
    input  logic              masked_mode,
    output u8f_pkg::result_t  res
);

    logic [1:0]               rem_reg,     rem_next;
    logic [2:0]               len_reg,     len_next;
    logic [u8f_pkg::CP_W-1:0] part_reg,    part_next;
    logic                     halted_reg,  halted_next;
    u8f_pkg::refusal_t        refusal_reg, refusal_next;

    logic [1:0]               rem_dec;
    logic [2:0]               len_dec;
    logic [u8f_pkg::CP_W-1:0] part_dec;
    logic                     bad_seq;
    logic                     done;
    logic                     bad;
    logic                     range_bad;
    logic [u8f_pkg::CP_W-1:0] min_value;
    u8f_pkg::judge_t          verdict;

    always_comb
    begin
        rem_dec  = rem_reg;
        len_dec  = len_reg;
        part_dec = part_reg;
        bad_seq  = 1'b0;
        done     = 1'b0;
        if (rem_reg == 2'd0)
        begin
            priority if (byte_value[7] == 1'b0)
            begin
                len_dec  = 3'd1;
                part_dec = {13'd0, byte_value};
                done     = 1'b1;
            end
            else if (byte_value[7:5] == 3'b110)
            begin
                len_dec  = 3'd2;
                part_dec = {16'd0, byte_value[4:0]};
                rem_dec  = 2'd1;
            end
            else if (byte_value[7:4] == 4'b1110)
            begin
                len_dec  = 3'd3;
                part_dec = {17'd0, byte_value[3:0]};
                rem_dec  = 2'd2;
            end
            else if (byte_value[7:3] == 5'b11110)
            begin
                len_dec  = 3'd4;
                part_dec = {18'd0, byte_value[2:0]};
                rem_dec  = 2'd3;
            end
            else
            begin
                bad_seq = 1'b1;
            end
        end
        else if (byte_value[7:6] != 2'b10)
        begin
            bad_seq = 1'b1;
        end
        else
        begin
            part_dec = {part_reg[u8f_pkg::CP_W-7:0], byte_value[5:0]};
            rem_dec  = rem_reg - 2'd1;
            done     = (rem_reg == 2'd1);
        end

        unique case (len_dec)
            3'd2:    min_value = u8f_pkg::MIN_TWO;
            3'd3:    min_value = u8f_pkg::MIN_THREE;
            3'd4:    min_value = u8f_pkg::MIN_FOUR;
            default: min_value = '0;
        endcase
        range_bad = (part_dec < min_value)
                  || ((part_dec >= u8f_pkg::SURR_LO) && (part_dec <= u8f_pkg::SURR_HI))
                  || (part_dec > u8f_pkg::CP_MAX);
    end

    u8f_judge u_judge (
        .value       (part_dec),
        .filter_mode (filter_mode),
        .masked_mode (masked_mode),
        .verdict     (verdict)
    );

    always_comb
    begin
        rem_next     = rem_dec;
        len_next     = len_dec;
        part_next    = part_dec;
        halted_next  = halted_reg;
        refusal_next = refusal_reg;
        res.kind          = u8f_pkg::KIND_NONE;
        res.code_point    = '0;
        bad          = 1'b0;

        if (halted_reg)
        begin
            rem_next  = rem_reg;
            len_next  = len_reg;
            part_next = part_reg;
        end
        else
        begin
            bad = bad_seq || (done && range_bad) || (!bad_seq && !done && end_of_string);
            if (done)
            begin
                len_next  = 3'd0;
                part_next = '0;
                if (!range_bad)
                begin
                    res.kind = verdict.kind;
                    if (verdict.kind == u8f_pkg::KIND_ACCEPT)
                    begin
                        res.code_point = verdict.kept;
                    end
                    else if (refusal_reg == u8f_pkg::REF_NONE)
                    begin
                        refusal_next = (verdict.kind == u8f_pkg::KIND_FORBID)
                                     ? u8f_pkg::REF_FORBID : u8f_pkg::REF_FONT;
                    end
                end
            end
            if (bad)
            begin
                res.kind       = u8f_pkg::KIND_BAD;
                res.code_point = '0;
                halted_next    = 1'b1;
                rem_next       = 2'd0;
                len_next       = 3'd0;
                part_next      = '0;
                if (refusal_reg == u8f_pkg::REF_NONE)
                begin
                    refusal_next = u8f_pkg::REF_BAD;
                end
            end
        end

        res.first_refusal = refusal_next;

        if (end_of_string)
        begin
            rem_next     = 2'd0;
            len_next     = 3'd0;
            part_next    = '0;
            halted_next  = 1'b0;
            refusal_next = u8f_pkg::REF_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg     <= 2'd0;
            len_reg     <= 3'd0;
            part_reg    <= '0;
            halted_reg  <= 1'b0;
            refusal_reg <= u8f_pkg::REF_NONE;
        end
        else if (step)
        begin
            rem_reg     <= rem_next;
            len_reg     <= len_next;
            part_reg    <= part_next;
            halted_reg  <= halted_next;
            refusal_reg <= refusal_next;
        end
    end

    a_halt_has_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (refusal_reg != u8f_pkg::REF_NONE))
        else $error("halted without a refusal");

    a_bad_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (res.kind == u8f_pkg::KIND_BAD) && !end_of_string) |=> halted_reg)
        else $error("malformed sequence did not halt the string");

    a_halt_idle_seq: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> ((rem_reg == 2'd0) && (len_reg == 3'd0)))
        else $error("sequence state left over while halted");

    a_cp_only_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (res.kind != u8f_pkg::KIND_ACCEPT) |-> (res.code_point == '0))
        else $error("code point on a result that is not accepted");

endmodule

[rtl/core/utf8_decode_and_char_filter_unit.sv]
// top level: input register, utf-8 decode and filter, result register, config registers
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata: byte_value; tlast: end_of_string
// m_axis    out  m_axis_tvalid/tready       tdata: code_point, first_refusal;
//                                           tuser: result_kind; tlast: string_done
// cfg       in   cfg_we                     cfg_index selects register, cfg_data value
//
// one word in, one word out; a new word is taken every cycle when the output flows
// a word passes the input register, then decode, filter and result register
// the per-string state advances once per word as it moves into the result register
// a stalled output holds the result and one more word waits in the input register
// reset clears the valid flags of both registers, the string state and the config registers
module utf8_decode_and_char_filter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [22:21] first_refusal
    output logic [2:0]  m_axis_tuser,   // [2:0] result_kind
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data
);

    logic                     in_valid_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_last_reg;
    logic                     out_valid_reg;
    u8f_pkg::result_t         out_res_reg;
    logic                     out_last_reg;
    logic [1:0]               filter_mode_reg;
    logic                     masked_mode_reg;
    logic                     advance;
    u8f_pkg::result_t         res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    u8f_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .byte_value    (in_byte_reg),
        .end_of_string (in_last_reg),
        .filter_mode   (filter_mode_reg),
        .masked_mode   (masked_mode_reg),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            out_res_reg  <= res;
            out_last_reg <= in_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg <= u8f_pkg::MODE_FREE;
            masked_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                u8f_pkg::CFG_FILTER_MODE: filter_mode_reg <= cfg_data;
                u8f_pkg::CFG_MASKED_MODE: masked_mode_reg <= cfg_data[0];
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_res_reg.first_refusal, out_res_reg.code_point};
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_last_reg;

endmodule

[dv/u8f_checker.sv]
// checker for the utf-8 decode and character filter unit: predicts each output word and compares
module u8f_checker
    import u8f_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [20:0] code_point, [22:21] first_refusal
    input  logic [2:0]  m_axis_tuser,   // [2:0] result_kind
    input  logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data,
    output int          results_owed,
    output int          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        kind_t           kind;
        logic [CP_W-1:0] cp;
        refusal_t        refusal;
        logic            last;
    } char_result_t;

    localparam logic [255:0] ROOM_SET = "ABCDEFGHJKLMNPQRSTUVWXYZ23456789";

    char_result_t    char_results_q[$];
    logic [1:0]      cfg_filter;
    logic            cfg_masked;
    logic [1:0]      cont_left;
    logic [2:0]      seq_len;
    logic [CP_W-1:0] cp_accum;
    logic            string_halted;
    refusal_t        string_refusal;
    int              mismatches;

    function automatic logic in_room_set(input logic [CP_W-1:0] v);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 32; i++)
            if (v == {13'd0, ROOM_SET[8*i +: 8]})
                hit = 1'b1;
        return hit;
    endfunction

    function automatic kind_t judge_char(input logic [CP_W-1:0] v,
                                         output logic [CP_W-1:0] kept);
        logic [CP_W-1:0] up;
        logic            name_ok;
        kept = '0;
        if (v < CTRL_LIMIT || v == DEL_CHAR)
            return KIND_FORBID;
        if (v > PRINT_LAST)
        begin
            if (cfg_masked && cfg_filter == MODE_FREE)
            begin
                kept = v;
                return KIND_ACCEPT;
            end
            return KIND_FONT;
        end
        if (cfg_filter == MODE_NAME)
        begin
            name_ok = (v >= 21'h41 && v <= 21'h5A) || (v >= 21'h61 && v <= 21'h7A) ||
                      (v >= 21'h30 && v <= 21'h39) || v == 21'h2D || v == 21'h5F;
            if (!name_ok)
                return KIND_FORBID;
        end
        else if (cfg_filter == MODE_ROOM)
        begin
            up = (v >= 21'h61 && v <= 21'h7A) ? v - 21'h20 : v;
            if (!in_room_set(up))
                return KIND_FORBID;
            kept = up;
            return KIND_ACCEPT;
        end
        kept = v;
        return KIND_ACCEPT;
    endfunction

    task automatic clear_string();
        cont_left      = 2'd0;
        seq_len        = 3'd0;
        cp_accum       = '0;
        string_halted  = 1'b0;
        string_refusal = REF_NONE;
    endtask

    task automatic note_refusal(input refusal_t code);
        if (string_refusal == REF_NONE)
            string_refusal = code;
    endtask

    task automatic decode_and_judge(input logic [7:0] b, input logic eos,
                                    output char_result_t res);
        logic            bad;
        logic            done;
        logic [CP_W-1:0] v;
        logic [CP_W-1:0] floor_v;
        logic [CP_W-1:0] kept;
        kind_t           k;
        res.kind = KIND_NONE;
        res.cp   = '0;
        if (!string_halted)
        begin
            bad  = 1'b0;
            done = 1'b0;
            if (cont_left == 2'd0)
            begin
                if (b[7] == 1'b0)
                begin
                    seq_len  = 3'd1;
                    cp_accum = {13'd0, b};
                    done     = 1'b1;
                end
                else if (b[7:5] == 3'b110)
                begin
                    seq_len   = 3'd2;
                    cp_accum  = {16'd0, b[4:0]};
                    cont_left = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    seq_len   = 3'd3;
                    cp_accum  = {17'd0, b[3:0]};
                    cont_left = 2'd2;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    seq_len   = 3'd4;
                    cp_accum  = {18'd0, b[2:0]};
                    cont_left = 2'd3;
                end
                else
                    bad = 1'b1;
            end
            else if (b[7:6] != 2'b10)
                bad = 1'b1;
            else
            begin
                cp_accum  = {cp_accum[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                done      = (cont_left == 2'd0);
            end

            // sequence cut off by the end of the string
            if (!bad && !done && eos)
                bad = 1'b1;

            if (done)
            begin
                v = cp_accum;
                case (seq_len)
                    3'd2:    floor_v = MIN_TWO;
                    3'd3:    floor_v = MIN_THREE;
                    3'd4:    floor_v = MIN_FOUR;
                    default: floor_v = '0;
                endcase
                if (v < floor_v || (v >= SURR_LO && v <= SURR_HI) || v > CP_MAX)
                    bad = 1'b1;
                else
                begin
                    k = judge_char(v, kept);
                    res.kind = k;
                    if (k == KIND_ACCEPT)
                        res.cp = kept;
                    else if (k == KIND_FORBID)
                        note_refusal(REF_FORBID);
                    else
                        note_refusal(REF_FONT);
                end
                seq_len  = 3'd0;
                cp_accum = '0;
            end

            if (bad)
            begin
                res.kind      = KIND_BAD;
                res.cp        = '0;
                string_halted = 1'b1;
                cont_left     = 2'd0;
                seq_len       = 3'd0;
                cp_accum      = '0;
                note_refusal(REF_BAD);
            end
        end
        res.refusal = string_refusal;
        res.last    = eos;
        if (eos)
            clear_string();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        char_result_t fresh;
        char_result_t want;
        if (!rst_n)
        begin
            char_results_q.delete();
            cfg_filter = MODE_FREE;
            cfg_masked = 1'b0;
            clear_string();
            mismatches   = 0;
            results_owed <= 0;
            fail_count   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_FILTER_MODE)
                    cfg_filter = cfg_data;
                else
                    cfg_masked = cfg_data[0];
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_and_judge(s_axis_tdata, s_axis_tlast, fresh);
                char_results_q.push_back(fresh);
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (char_results_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("mismatch: unexpected word tdata %h tuser %0d tlast %0b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = char_results_q.pop_front();
                    if (m_axis_tuser != want.kind || m_axis_tdata[20:0] != want.cp ||
                        m_axis_tdata[22:21] != want.refusal || m_axis_tlast != want.last)
                    begin
                        if (mismatches < 10)
                        begin
                            $write("mismatch (expected/actual): kind %0d/%0d cp %h/%h ",
                                   want.kind, m_axis_tuser, want.cp, m_axis_tdata[20:0]);
                            $display("refusal %0d/%0d last %0b/%0b",
                                     want.refusal, m_axis_tdata[22:21],
                                     want.last, m_axis_tlast);
                        end
                        mismatches++;
                    end
                end
            end

            results_owed <= char_results_q.size();
            fail_count   <= mismatches;
        end
    end

endmodule

[dv/tb.sv]
// testbench top: clock, reset, byte stream stimulus, config writes and the verdict
module tb;
    import u8f_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         PHASE_BYTES = 110;

    typedef enum int {
        CH_PRINT,
        CH_NAME_SYM,
        CH_CTRL,
        CH_TWO,
        CH_THREE,
        CH_FOUR,
        CH_OVERLONG,
        CH_SURROGATE,
        CH_TOO_BIG,
        CH_BAD_LEAD,
        CH_NO_CONT,
        CH_TRUNC
    } char_class_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] byte_value
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // [20:0] code_point, [22:21] first_refusal
    logic [2:0]  m_axis_tuser;            // [2:0] result_kind
    logic        m_axis_tlast;
    logic        cfg_we        = 1'b0;
    logic        cfg_index     = CFG_FILTER_MODE;
    logic [1:0]  cfg_data      = 2'd0;

    int          results_owed;
    int          fail_count;
    int          quiet_cycles  = 0;
    bit          calm          = 1'b0;
    logic [7:0]  str_bytes[$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    utf8_decode_and_char_filter_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    u8f_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .results_owed  (results_owed),
        .fail_count    (fail_count)
    );

    always @(posedge clk)
    begin
        if (!calm && $urandom_range(0, 99) < 16)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("tb failed");
        $finish;
    end

    task automatic send_word(input logic [7:0] b, input logic last);
        bit hit;
        while (!calm && $urandom_range(0, 99) < 16)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
        begin
            @(negedge clk);
            hit = s_axis_tready;
            @(posedge clk);
        end
        while (!hit);
    endtask

    task automatic send_string();
        for (int i = 0; i < str_bytes.size(); i++)
            send_word(str_bytes[i], i == str_bytes.size() - 1);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [1:0] mode, input logic masked);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FILTER_MODE;
        cfg_data  <= mode;
        @(posedge clk);
        cfg_index <= CFG_MASKED_MODE;
        cfg_data  <= {1'b0, masked};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] lead_byte(input int len);
        case (len)
            2:       return 8'($urandom_range(8'hC2, 8'hDF));
            3:       return 8'($urandom_range(8'hE1, 8'hEC));
            default: return 8'($urandom_range(8'hF1, 8'hF3));
        endcase
    endfunction

    task automatic put_code(input logic [20:0] cp);
        if (cp < MIN_TWO)
            str_bytes.push_back(cp[7:0]);
        else if (cp < MIN_THREE)
        begin
            str_bytes.push_back({3'b110, cp[10:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end
        else if (cp < MIN_FOUR)
        begin
            str_bytes.push_back({4'b1110, cp[15:12]});
            str_bytes.push_back({2'b10, cp[11:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            str_bytes.push_back({5'b11110, cp[20:18]});
            str_bytes.push_back({2'b10, cp[17:12]});
            str_bytes.push_back({2'b10, cp[11:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end
    endtask

    function automatic char_class_t pick_class();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)      return CH_PRINT;
        else if (r < 45) return CH_NAME_SYM;
        else if (r < 50) return CH_CTRL;
        else if (r < 60) return CH_TWO;
        else if (r < 68) return CH_THREE;
        else if (r < 76) return CH_FOUR;
        else if (r < 80) return CH_OVERLONG;
        else if (r < 83) return CH_SURROGATE;
        else if (r < 86) return CH_TOO_BIG;
        else if (r < 90) return CH_BAD_LEAD;
        else if (r < 95) return CH_NO_CONT;
        else             return CH_TRUNC;
    endfunction

    task automatic put_random_char(output bit cut);
        char_class_t cls;
        logic [20:0] cp;
        int          len;
        int          r;
        cut = 1'b0;
        cls = pick_class();
        case (cls)
            CH_PRINT:
                str_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
            CH_NAME_SYM:
            begin
                r = $urandom_range(0, 4);
                case (r)
                    0:       str_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
                    1:       str_bytes.push_back(8'h41 + 8'($urandom_range(0, 25)));
                    2:       str_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
                    3:       str_bytes.push_back(8'h2D);
                    default: str_bytes.push_back(8'h5F);
                endcase
            end
            CH_CTRL:
                if ($urandom_range(0, 3) == 0)
                    str_bytes.push_back(8'h7F);
                else
                    str_bytes.push_back(8'($urandom_range(8'h01, 8'h1F)));
            CH_TWO:
                put_code(21'($urandom_range(21'h80, 21'h7FF)));
            CH_THREE:
            begin
                cp = 21'($urandom_range(21'h800, 21'hFFFF));
                if (cp >= SURR_LO && cp <= SURR_HI)
                    cp = cp ^ 21'h1000;
                put_code(cp);
            end
            CH_FOUR:
                put_code(21'($urandom_range(21'h10000, 21'h10FFFF)));
            CH_OVERLONG:
            begin
                r = $urandom_range(0, 2);
                if (r == 0)
                    str_bytes.push_back(8'hC0 | 8'($urandom_range(0, 1)));
                else if (r == 1)
                begin
                    str_bytes.push_back(8'hE0);
                    str_bytes.push_back(8'h80 | 8'($urandom_range(0, 31)));
                end
                else
                begin
                    str_bytes.push_back(8'hF0);
                    str_bytes.push_back(8'h80 | 8'($urandom_range(0, 15)));
                    str_bytes.push_back(cont_byte());
                end
                str_bytes.push_back(cont_byte());
            end
            CH_SURROGATE:
            begin
                str_bytes.push_back(8'hED);
                str_bytes.push_back(8'hA0 | 8'($urandom_range(0, 31)));
                str_bytes.push_back(cont_byte());
            end
            CH_TOO_BIG:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    str_bytes.push_back(8'hF4);
                    str_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
                end
                else
                begin
                    str_bytes.push_back(8'($urandom_range(8'hF5, 8'hF7)));
                    str_bytes.push_back(cont_byte());
                end
                str_bytes.push_back(cont_byte());
                str_bytes.push_back(cont_byte());
            end
            CH_BAD_LEAD:
                if ($urandom_range(0, 1) == 0)
                    str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                else
                    str_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
            CH_NO_CONT:
            begin
                len = $urandom_range(2, 4);
                str_bytes.push_back(lead_byte(len));
                repeat ($urandom_range(0, len - 2)) str_bytes.push_back(cont_byte());
                if ($urandom_range(0, 1) == 0)
                    str_bytes.push_back(8'($urandom_range(8'h01, 8'h7F)));
                else
                    str_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
            end
            default:
            begin
                len = $urandom_range(2, 4);
                str_bytes.push_back(lead_byte(len));
                repeat ($urandom_range(0, len - 2)) str_bytes.push_back(cont_byte());
                cut = 1'b1;
            end
        endcase
    endtask

    task automatic build_string();
        int n_chars;
        bit cut;
        str_bytes.delete();
        n_chars = $urandom_range(1, 6);
        cut = 1'b0;
        for (int i = 0; i < n_chars && !cut; i++)
            put_random_char(cut);
    endtask

    initial
    begin
        int          sent;
        logic [1:0]  mode;
        logic        masked;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings: limits, every filter mode, every kind of fault
        settle();
        apply_setting(MODE_FREE, 1'b1);
        str_bytes = '{8'h41, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h1F};
        send_string();
        settle();
        apply_setting(MODE_NAME, 1'b0);
        str_bytes = '{8'h5F, 8'hC3, 8'hA9, 8'h21};
        send_string();
        settle();
        apply_setting(MODE_ROOM, 1'b0);
        str_bytes = '{8'h61, 8'h69};
        send_string();
        settle();
        apply_setting(MODE_SPARE, 1'b1);
        str_bytes = '{8'hC3, 8'hA9, 8'hC0, 8'h80, 8'h41};
        send_string();
        str_bytes = '{8'hED, 8'hA0, 8'h80};
        send_string();
        str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_string();
        str_bytes = '{8'hFF};
        send_string();
        str_bytes = '{8'hE2, 8'h41};
        send_string();
        str_bytes = '{8'hE2, 8'h82};
        send_string();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    mode   = MODE_FREE;
                    masked = 1'b1;
                end
                1:
                begin
                    mode   = MODE_ROOM;
                    masked = 1'b0;
                end
                2:
                begin
                    mode   = MODE_SPARE;
                    masked = 1'b1;
                end
                3:
                begin
                    mode   = MODE_NAME;
                    masked = 1'b1;
                end
                default:
                begin
                    mode   = 2'($urandom_range(0, 3));
                    masked = 1'($urandom_range(0, 1));
                end
            endcase
            settle();
            calm <= (phase == 2);
            apply_setting(mode, masked);
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                build_string();
                send_string();
                sent += str_bytes.size();
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
